@@ rtl/pmsp_pkg.sv @@
// Package for the permission mode string parser: character codes, parser types,
// and the mask helper functions for the symbolic reading. No dependencies.
`default_nettype none

package pmsp_pkg;

  localparam int unsigned CHAR_W = 8;
  localparam int unsigned MASK_W = 12;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned MAX_DIGITS = 4;

  // Character codes used by the grammar.
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_BSL   = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
  localparam logic [CHAR_W-1:0] CH_G     = 8'h67;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6F;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CH_R     = 8'h72;
  localparam logic [CHAR_W-1:0] CH_W     = 8'h77;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_S     = 8'h73;
  localparam logic [CHAR_W-1:0] CH_T     = 8'h74;

  // Action codes reported on the result.
  localparam logic [1:0] ACT_SET = 2'd0;
  localparam logic [1:0] ACT_ADD = 2'd1;
  localparam logic [1:0] ACT_SUB = 2'd2;
  localparam logic [1:0] ACT_BSL = 2'd3;

  // Selector and permission bit groups.
  localparam logic [MASK_W-1:0] SEL_U    = 12'o4700;
  localparam logic [MASK_W-1:0] SEL_G    = 12'o2070;
  localparam logic [MASK_W-1:0] SEL_O    = 12'o1007;
  localparam logic [MASK_W-1:0] SEL_ALL  = 12'o7777;
  localparam logic [MASK_W-1:0] BITS_R   = 12'o0444;
  localparam logic [MASK_W-1:0] BITS_W   = 12'o0222;
  localparam logic [MASK_W-1:0] BITS_X   = 12'o0111;
  localparam logic [MASK_W-1:0] BITS_SUID = 12'o4000;
  localparam logic [MASK_W-1:0] BITS_SGID = 12'o2000;
  localparam logic [MASK_W-1:0] BITS_STKY = 12'o1000;
  localparam logic [MASK_W-1:0] BITS_S   = BITS_SUID | BITS_SGID;
  localparam logic [MASK_W-1:0] BITS_T   = BITS_STKY;
  localparam logic [MASK_W-1:0] GRP_U    = 12'o0700;
  localparam logic [MASK_W-1:0] GRP_G    = 12'o0070;
  localparam logic [MASK_W-1:0] GRP_O    = 12'o0007;

  typedef enum logic [1:0] {
    PH_SEL,
    PH_OP,
    PH_RUN,
    PH_COPY
  } phase_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_SET
  } op_t;

  // State of one symbolic reading.
  typedef struct packed {
    logic              live;
    phase_t            phase;
    logic [MASK_W-1:0] mask;
    logic [MASK_W-1:0] sel;
    op_t               op;
    logic [MASK_W-1:0] bits;
  } hyp_t;

  localparam hyp_t HYP_RESET = '{
    live:  1'b1,
    phase: PH_SEL,
    mask:  '0,
    sel:   '0,
    op:    OP_NONE,
    bits:  '0
  };

  // Per-character controls for one symbolic reading.
  typedef struct packed {
    logic step;  // a character is processed this cycle
    logic call;  // the character is fed to this reading
    logic kill;  // the reading is dropped by this character
    logic last;  // the character ends the expression
  } hyp_ctrl_t;

  typedef struct packed {
    logic              live;
    logic [MASK_W-1:0] mask;
  } hyp_res_t;

  function automatic logic is_action(input logic [CHAR_W-1:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_EQ);
  endfunction

  function automatic logic is_mode_char(input logic [CHAR_W-1:0] c);
    return is_action(c) || (c == CH_BSL);
  endfunction

  function automatic logic [MASK_W-1:0] run_bits(input logic [CHAR_W-1:0] c);
    logic [MASK_W-1:0] r;
    unique case (c)
      CH_R:    r = BITS_R;
      CH_W:    r = BITS_W;
      CH_X:    r = BITS_X;
      CH_S:    r = BITS_S;
      CH_T:    r = BITS_T;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Copy the permissions of one class (u, g or o) to every class.
  function automatic logic [MASK_W-1:0] copy_bits(input logic [MASK_W-1:0] m,
                                                   input logic [CHAR_W-1:0] c);
    logic [MASK_W-1:0] b;
    b = '0;
    if (c == CH_U) begin
      b = m & GRP_U;
      b = b | (b >> 3) | (b >> 6) | (m & BITS_SUID);
    end else if (c == CH_G) begin
      b = m & GRP_G;
      b = b | (b >> 3) | (b << 3) | (m & BITS_SGID);
    end else begin
      b = m & GRP_O;
      b = b | (b << 6) | (b << 3) | (m & BITS_STKY);
    end
    return b;
  endfunction

  // Fold the pending action into the mask.
  function automatic logic [MASK_W-1:0] commit_mask(input hyp_t h);
    logic [MASK_W-1:0] b;
    logic [MASK_W-1:0] m;
    b = h.bits & h.sel;
    m = h.mask;
    unique case (h.op)
      OP_ADD:  m = m | b;
      OP_SUB:  m = m & ~b;
      OP_SET:  m = (m & ~h.sel) | b;
      default: m = h.mask;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ rtl/pmsp_if.sv @@
// Valid/ready channels for parser characters and parse results.
// Depends on pmsp_pkg for field widths.
`default_nettype none

interface pmsp_in_if;
  logic                         valid;
  logic                         ready;
  logic [pmsp_pkg::CHAR_W-1:0]  char_code;
  logic                         last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface pmsp_out_if;
  logic                         valid;
  logic                         ready;
  logic                         valid_res;
  logic [pmsp_pkg::MASK_W-1:0]  perm_mask;
  logic [1:0]                   apply_action;

  modport source (output valid, output valid_res, output perm_mask, output apply_action,
                  input ready);
  modport sink   (input valid, input valid_res, input perm_mask, input apply_action,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/pmsp_hyp.sv @@
// One symbolic reading of the expression: holds its state and folds actions.
// Depends on pmsp_pkg.
`default_nettype none

module pmsp_hyp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire pmsp_pkg::hyp_ctrl_t         ctrl,
  input  wire logic [pmsp_pkg::CHAR_W-1:0] ch,
  output pmsp_pkg::hyp_res_t               res
);
  import pmsp_pkg::*;

  hyp_t cur;
  hyp_t upd;
  hyp_t cur_next;

  always_comb begin
    upd = cur;
    if (ctrl.call && cur.live) begin
      priority if (cur.phase == PH_SEL &&
                   (ch == CH_U || ch == CH_G || ch == CH_O || ch == CH_A)) begin
        priority case (ch)
          CH_U:    upd.sel = cur.sel | SEL_U;
          CH_G:    upd.sel = cur.sel | SEL_G;
          CH_O:    upd.sel = cur.sel | SEL_O;
          default: upd.sel = SEL_ALL;
        endcase
      end else if (is_action(ch)) begin
        if (cur.phase == PH_SEL) begin
          if (cur.sel == '0) begin
            upd.sel = SEL_ALL;
          end
        end else begin
          upd.mask = commit_mask(cur);
        end
        priority case (ch)
          CH_PLUS:  upd.op = OP_ADD;
          CH_MINUS: upd.op = OP_SUB;
          default:  upd.op = OP_SET;
        endcase
        upd.bits  = '0;
        upd.phase = PH_OP;
      end else if (cur.phase == PH_OP && (ch == CH_U || ch == CH_G || ch == CH_O)) begin
        upd.bits  = copy_bits(cur.mask, ch);
        upd.phase = PH_COPY;
      end else if ((cur.phase == PH_OP || cur.phase == PH_RUN) && run_bits(ch) != '0) begin
        upd.bits  = cur.bits | run_bits(ch);
        upd.phase = PH_RUN;
      end else if (ch == CH_COMMA && cur.phase != PH_SEL) begin
        upd.mask  = commit_mask(cur);
        upd.op    = OP_NONE;
        upd.bits  = '0;
        upd.sel   = '0;
        upd.phase = PH_SEL;
      end else begin
        upd.live = 1'b0;
      end
    end
    if (ctrl.kill) begin
      upd.live = 1'b0;
    end

    // A reading that ends inside a selector (empty or trailing token) is invalid.
    res.live = upd.live && (upd.phase != PH_SEL);
    res.mask = commit_mask(upd);

    cur_next = ctrl.last ? HYP_RESET : upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= HYP_RESET;
    end else if (ctrl.step) begin
      cur <= cur_next;
    end
  end

endmodule

`default_nettype wire

@@ rtl/permission_mode_string_parser_core.sv @@
// Permission expression parser, one character per item, one result per expression.
// An accepted character is held in the input register; the result of the last
// character is then written into the result register when it is free.
// Throughput: one character per cycle; limited only by the result register draining.
// Reset (rst, synchronous, active high) empties both registers and restarts parsing.
`default_nettype none

module permission_mode_string_parser_core (
  input  wire logic clk,
  input  wire logic rst,
  pmsp_in_if.sink   din,
  pmsp_out_if.source dout
);
  import pmsp_pkg::*;

  // Input register. Characters that do not end the expression never need the
  // result register, so they move on even while a result waits to be taken.
  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  logic              proc;

  assign proc      = s1_valid && (!s1_last || !dout.valid || dout.ready);
  assign din.ready = !s1_valid || proc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.ready) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.ready && din.valid) begin
      s1_char <= din.char_code;
      s1_last <= din.last_char;
    end
  end

  // The first character decides whether a mode character leads the expression.
  // If it does, it is consumed as the mode by the mode reading (hypothesis 1),
  // while hypothesis 0 still sees it as a first action. The numeric reading
  // skips a leading mode character.
  logic              first_seen;
  logic [1:0]        mode_code;
  logic [MASK_W-1:0] num_value;
  logic [CNT_W-1:0]  digit_count;
  logic              num_live;

  logic              lead_mode;
  logic              num_call;
  logic [1:0]        mode_n;
  logic [MASK_W-1:0] num_value_n;
  logic [CNT_W-1:0]  digit_count_n;
  logic              num_live_n;
  logic              is_digit;

  assign lead_mode = !first_seen && is_mode_char(s1_char);
  assign num_call  = first_seen || !is_mode_char(s1_char);
  assign is_digit  = (s1_char >= CH_ZERO) && (s1_char <= CH_SEVEN);

  always_comb begin
    mode_n = mode_code;
    if (!first_seen) begin
      priority case (s1_char)
        CH_PLUS:  mode_n = ACT_ADD;
        CH_MINUS: mode_n = ACT_SUB;
        CH_BSL:   mode_n = ACT_BSL;
        default:  mode_n = ACT_SET;
      endcase
    end

    num_value_n   = num_value;
    digit_count_n = digit_count;
    num_live_n    = num_live;
    if (num_call && num_live) begin
      if (is_digit && digit_count < CNT_W'(MAX_DIGITS)) begin
        num_value_n   = {num_value[MASK_W-4:0], s1_char[2:0]};
        digit_count_n = digit_count + CNT_W'(1);
      end else begin
        num_live_n = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_seen  <= 1'b0;
      mode_code   <= ACT_SET;
      num_value   <= '0;
      digit_count <= '0;
      num_live    <= 1'b1;
    end else if (proc) begin
      if (s1_last) begin
        first_seen  <= 1'b0;
        mode_code   <= ACT_SET;
        num_value   <= '0;
        digit_count <= '0;
        num_live    <= 1'b1;
      end else begin
        first_seen  <= 1'b1;
        mode_code   <= mode_n;
        num_value   <= num_value_n;
        digit_count <= digit_count_n;
        num_live    <= num_live_n;
      end
    end
  end

  // Two symbolic readings: hypothesis 0 has no mode character, hypothesis 1
  // takes the first character as the mode.
  hyp_ctrl_t ctrl0;
  hyp_ctrl_t ctrl1;
  hyp_res_t  res0;
  hyp_res_t  res1;

  assign ctrl0 = '{step: proc, call: 1'b1, kill: 1'b0, last: s1_last};
  assign ctrl1 = '{step: proc, call: first_seen,
                   kill: !first_seen && !lead_mode, last: s1_last};

  pmsp_hyp u_hyp0 (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl0),
    .ch   (s1_char),
    .res  (res0)
  );

  pmsp_hyp u_hyp1 (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl1),
    .ch   (s1_char),
    .res  (res1)
  );

  // Result selection: the numeric reading wins, then the mode reading, then
  // the reading without a mode character (which reports '=' as its action).
  logic              res_valid_n;
  logic [MASK_W-1:0] res_mask_n;
  logic [1:0]        res_act_n;

  always_comb begin
    res_valid_n = 1'b0;
    res_mask_n  = '0;
    res_act_n   = ACT_SET;
    priority if (num_live_n && digit_count_n != '0) begin
      res_valid_n = 1'b1;
      res_mask_n  = num_value_n;
      res_act_n   = mode_n;
    end else if (res1.live) begin
      res_valid_n = 1'b1;
      res_mask_n  = res1.mask;
      res_act_n   = mode_n;
    end else if (res0.live) begin
      res_valid_n = 1'b1;
      res_mask_n  = res0.mask;
      res_act_n   = ACT_SET;
    end else begin
      res_valid_n = 1'b0;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (proc && s1_last) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && s1_last) begin
      dout.valid_res    <= res_valid_n;
      dout.perm_mask    <= res_mask_n;
      dout.apply_action <= res_act_n;
    end
  end

`ifndef SYNTHESIS
  // A new result only appears after a last character was processed.
  assert property (@(posedge clk) disable iff (rst)
    $rose(dout.valid) |-> $past(proc && s1_last))
    else $error("result appeared without a last character");

  // An invalid result carries a zero mask and the '=' action.
  assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.valid_res) |-> (dout.perm_mask == '0 && dout.apply_action == ACT_SET))
    else $error("invalid result carries nonzero fields");

  // The digit counter never passes the longest octal number.
  assert property (@(posedge clk) disable iff (rst)
    digit_count <= CNT_W'(MAX_DIGITS))
    else $error("digit count overflow");

  // A result held while stalled is not overwritten by a last character.
  assert property (@(posedge clk) disable iff (rst)
    (dout.valid && !dout.ready && s1_valid && s1_last) |-> !proc)
    else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
